// File: rtl/core/u2a_pkg.sv
// ----------------------------------------------------------------------------
// u2a_pkg
// Shared types, constants and the code point lowering function for the
// UTF-8 to 8-bit character lowering block.
// ----------------------------------------------------------------------------
package u2a_pkg;

    localparam int unsigned CODE_W = 21;
    localparam int unsigned BYTE_W = 8;

    // Lead byte thresholds (no validation, loose ranges)
    localparam logic [BYTE_W-1:0] ASCII_MAX = 8'h7F;
    localparam logic [BYTE_W-1:0] LEAD2_MAX = 8'hDF;
    localparam logic [BYTE_W-1:0] LEAD3_MAX = 8'hEF;

    // Code point ranges with replacements
    localparam logic [CODE_W-1:0] CP_ASCII_MAX  = 21'h00007F;
    localparam logic [CODE_W-1:0] CP_FW_FIRST   = 21'h00FF01;
    localparam logic [CODE_W-1:0] CP_FW_LAST    = 21'h00FF5E;
    localparam logic [CODE_W-1:0] CP_SPACE_LO   = 21'h002000;
    localparam logic [CODE_W-1:0] CP_SPACE_HI   = 21'h00200A;
    localparam logic [CODE_W-1:0] CP_NNBSP      = 21'h00202F;
    localparam logic [CODE_W-1:0] CP_MMSP       = 21'h00205F;
    localparam logic [CODE_W-1:0] CP_HFILL      = 21'h003164;
    localparam logic [CODE_W-1:0] CP_CJK_FIRST  = 21'h003000;
    localparam logic [CODE_W-1:0] CP_CJK_LAST   = 21'h00301F;
    localparam logic [CODE_W-1:0] CP_VREPEAT    = 21'h003031;

    // Replacement characters
    localparam logic [BYTE_W-1:0] CH_FW_BASE = 8'h21;
    localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [BYTE_W-1:0] CH_NBSP    = 8'hA0;
    localparam logic [BYTE_W-1:0] CH_LT      = 8'h3C;
    localparam logic [BYTE_W-1:0] CH_HASH    = 8'h23;

    // One decoded item handed from the front to the back
    typedef struct packed {
        logic              valid;
        logic [CODE_W-1:0] code;
        logic              last;
        logic              bad;
    } token_t;

    // Replacements for CJK punctuation U+3000..U+301F
    function automatic logic [BYTE_W-1:0] cjk_char(input logic [4:0] idx);
        logic [BYTE_W-1:0] ch;
        case (idx)
            5'd0:    ch = 8'h20;
            5'd1:    ch = 8'h2C;
            5'd2:    ch = 8'h2E;
            5'd3:    ch = 8'h22;
            5'd7:    ch = 8'h30;
            5'd8:    ch = 8'h3C;
            5'd9:    ch = 8'h3E;
            5'd10:   ch = 8'hAB;
            5'd11:   ch = 8'hBB;
            5'd12, 5'd14, 5'd16, 5'd20, 5'd22, 5'd24, 5'd26:
                     ch = 8'h5B;
            5'd13, 5'd15, 5'd17, 5'd21, 5'd23, 5'd25, 5'd27:
                     ch = 8'h5D;
            5'd28:   ch = 8'h7E;
            5'd29, 5'd30, 5'd31:
                     ch = 8'h22;
            default: ch = CH_HASH;
        endcase
        return ch;
    endfunction

    // Lower one code point to an 8-bit character
    function automatic logic [BYTE_W-1:0] lower_code(input logic [CODE_W-1:0] cp);
        logic [CODE_W-1:0] fw_off;
        logic [BYTE_W-1:0] ch;
        fw_off = cp - CP_FW_FIRST;
        if (cp <= CP_ASCII_MAX)
            ch = cp[BYTE_W-1:0];
        else if (cp >= CP_FW_FIRST && cp <= CP_FW_LAST)
            ch = CH_FW_BASE + fw_off[BYTE_W-1:0];
        else if (cp >= CP_SPACE_LO && cp <= CP_SPACE_HI)
            ch = CH_SPACE;
        else if (cp == CP_NNBSP)
            ch = CH_NBSP;
        else if (cp == CP_MMSP || cp == CP_HFILL)
            ch = CH_SPACE;
        else if (cp >= CP_CJK_FIRST && cp <= CP_CJK_LAST)
            ch = cjk_char(cp[4:0]);
        else if (cp == CP_VREPEAT)
            ch = CH_LT;
        else
            ch = CH_HASH;
        return ch;
    endfunction

endpackage

// File: rtl/core/u2a_front.sv
// ----------------------------------------------------------------------------
// u2a_front
// Accepts raw bytes, tracks the multibyte sequence and the stop flag, and
// emits one decoded token per accepted byte.
// ----------------------------------------------------------------------------
module u2a_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          take,
    input  logic [u2a_pkg::BYTE_W-1:0]    in_byte,
    input  logic                          end_of_string,
    output u2a_pkg::token_t               tok
);

    logic [1:0]                   pend_reg;
    logic [1:0]                   pend_next;
    logic [u2a_pkg::CODE_W-1:0]   acc_reg;
    logic [u2a_pkg::CODE_W-1:0]   acc_next;
    logic                         stop_reg;
    logic                         stop_next;
    logic [u2a_pkg::CODE_W-1:0]   acc_shift;

    // Shift six payload bits into the code point
    assign acc_shift = {acc_reg[u2a_pkg::CODE_W-7:0], in_byte[5:0]};

    // Classify the byte and compute the next sequence state
    always_comb
    begin
        pend_next = pend_reg;
        acc_next  = acc_reg;
        stop_next = stop_reg;
        tok.valid = 1'b0;
        tok.code  = '0;
        tok.last  = end_of_string;
        tok.bad   = 1'b0;
        if (!stop_reg)
        begin
            if (pend_reg != 2'd0)
            begin
                acc_next  = acc_shift;
                pend_next = pend_reg - 2'd1;
                if (pend_reg == 2'd1)
                begin
                    tok.valid = 1'b1;
                    tok.code  = acc_shift;
                end
            end
            else if (in_byte == '0)
            begin
                stop_next = 1'b1;
            end
            else if (in_byte <= u2a_pkg::ASCII_MAX)
            begin
                tok.valid = 1'b1;
                tok.code  = {{(u2a_pkg::CODE_W-u2a_pkg::BYTE_W){1'b0}}, in_byte};
            end
            else if (in_byte <= u2a_pkg::LEAD2_MAX)
            begin
                acc_next  = {{(u2a_pkg::CODE_W-5){1'b0}}, in_byte[4:0]};
                pend_next = 2'd1;
            end
            else if (in_byte <= u2a_pkg::LEAD3_MAX)
            begin
                acc_next  = {{(u2a_pkg::CODE_W-4){1'b0}}, in_byte[3:0]};
                pend_next = 2'd2;
            end
            else
            begin
                acc_next  = {{(u2a_pkg::CODE_W-3){1'b0}}, in_byte[2:0]};
                pend_next = 2'd3;
            end
        end
        // Flag a cut sequence and restart at string end
        if (end_of_string)
        begin
            tok.bad   = (pend_next != 2'd0);
            pend_next = 2'd0;
            acc_next  = '0;
            stop_next = 1'b0;
        end
    end

    // Advance state on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 2'd0;
            acc_reg  <= '0;
            stop_reg <= 1'b0;
        end
        else if (take)
        begin
            pend_reg <= pend_next;
            acc_reg  <= acc_next;
            stop_reg <= stop_next;
        end
    end

endmodule

// File: rtl/core/u2a_queue.sv
// ----------------------------------------------------------------------------
// u2a_queue
// Short token queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module u2a_queue
#(
    parameter int unsigned DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  u2a_pkg::token_t  wr_tok,
    output logic             full,
    input  logic             rd_en,
    output u2a_pkg::token_t  rd_tok,
    output logic             empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    u2a_pkg::token_t   slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;

    assign full   = (cnt_reg == CNT_FULL);
    assign empty  = (cnt_reg == '0);
    assign rd_tok = slot_reg[rd_ptr_reg];

    // Advance pointers with wrap and track the fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (rd_en)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (wr_en && !rd_en)
            cnt_next = cnt_reg + CNT_W'(1);
        else if (rd_en && !wr_en)
            cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the incoming token
    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_reg[wr_ptr_reg] <= wr_tok;
    end

endmodule

// File: rtl/core/u2a_back.sv
// ----------------------------------------------------------------------------
// u2a_back
// Lowers the code point at the queue head to one character and holds the
// result in an output register until it is popped.
// ----------------------------------------------------------------------------
module u2a_back
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  u2a_pkg::token_t             head_tok,
    input  logic                        head_empty,
    output logic                        head_pop,
    input  logic                        pop,
    output logic                        empty,
    output logic                        char_valid,
    output logic [u2a_pkg::BYTE_W-1:0]  ascii_char,
    output logic                        string_done,
    output logic                        malformed
);

    logic                        full_reg;
    logic                        full_next;
    logic                        valid_reg;
    logic [u2a_pkg::BYTE_W-1:0]  char_reg;
    logic                        done_reg;
    logic                        bad_reg;
    logic [u2a_pkg::BYTE_W-1:0]  char_next;

    // Load a new result when the register is free or being drained
    assign head_pop  = !head_empty && (!full_reg || pop);
    assign full_next = head_pop || (full_reg && !pop);
    assign char_next = head_tok.valid ? u2a_pkg::lower_code(head_tok.code) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            full_reg <= 1'b0;
        else
            full_reg <= full_next;
    end

    // Capture the lowered result
    always_ff @(posedge clk)
    begin
        if (head_pop)
        begin
            valid_reg <= head_tok.valid;
            char_reg  <= char_next;
            done_reg  <= head_tok.last;
            bad_reg   <= head_tok.bad;
        end
    end

    assign empty       = !full_reg;
    assign char_valid  = valid_reg;
    assign ascii_char  = char_reg;
    assign string_done = done_reg;
    assign malformed   = bad_reg;

endmodule

// File: rtl/core/utf8_to_ascii_lowering.sv
// ----------------------------------------------------------------------------
// utf8_to_ascii_lowering
// Lowers a UTF-8 byte stream to 8-bit characters, one result per byte.
//
//   Channel | Handshake        | Payload
//   --------+------------------+--------------------------------------------
//   input   | push / full      | in_byte, end_of_string
//   result  | empty / pop      | char_valid, ascii_char, string_done, malformed
//
// One byte is accepted per cycle while full is low; each byte gives exactly one result.
// A byte is decoded and queued at its transfer edge and lowered into the output
// register once that register is free or being popped; it can then be popped.
// The token queue (QUEUE_DEPTH entries) plus the output register absorb
// stalls on pop; full rises only once both are occupied.
// Reset clears the sequence state and empties the queue and the output register.
// ----------------------------------------------------------------------------
module utf8_to_ascii_lowering
#(
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [u2a_pkg::BYTE_W-1:0]  in_byte,
    input  logic                        end_of_string,
    output logic                        empty,
    input  logic                        pop,
    output logic                        char_valid,
    output logic [u2a_pkg::BYTE_W-1:0]  ascii_char,
    output logic                        string_done,
    output logic                        malformed
);

    logic             take;
    logic             q_full;
    logic             q_empty;
    logic             q_pop;
    u2a_pkg::token_t  front_tok;
    u2a_pkg::token_t  head_tok;

    // Transfer a byte whenever the queue has room
    assign full = q_full;
    assign take = push && !q_full;

    u2a_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (take),
        .in_byte       (in_byte),
        .end_of_string (end_of_string),
        .tok           (front_tok)
    );

    u2a_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (take),
        .wr_tok (front_tok),
        .full   (q_full),
        .rd_en  (q_pop),
        .rd_tok (head_tok),
        .empty  (q_empty)
    );

    u2a_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_tok    (head_tok),
        .head_empty  (q_empty),
        .head_pop    (q_pop),
        .pop         (pop),
        .empty       (empty),
        .char_valid  (char_valid),
        .ascii_char  (ascii_char),
        .string_done (string_done),
        .malformed   (malformed)
    );

endmodule

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// UTF-8 lowering block testbench
// Streams UTF-8 strings into utf8_to_ascii_lowering through its push/full
// side and pulls one result per byte through its empty/pop side. A local
// decoder predicts every result, and each transfer on the result side is
// checked field by field against the oldest prediction. Both sides idle at
// random; one long receiver hold-off fills the block and stalls its input.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned RANDOM_BYTES = 1450;
    localparam int unsigned MAX_PRINTS = 40;

    // Code points with special replacements
    localparam logic [20:0] CP_FW_LO    = 21'h00FF01;
    localparam logic [20:0] CP_FW_HI    = 21'h00FF5E;
    localparam logic [20:0] CP_SP_LO    = 21'h002000;
    localparam logic [20:0] CP_SP_HI    = 21'h00200A;
    localparam logic [20:0] CP_NARROW   = 21'h00202F;
    localparam logic [20:0] CP_MATH_SP  = 21'h00205F;
    localparam logic [20:0] CP_FILLER   = 21'h003164;
    localparam logic [20:0] CP_PUNCT_LO = 21'h003000;
    localparam logic [20:0] CP_PUNCT_HI = 21'h00301F;
    localparam logic [20:0] CP_REPEAT   = 21'h003031;
    localparam logic [7:0]  CHR_SPACE   = 8'h20;
    localparam logic [7:0]  CHR_NBSP    = 8'hA0;
    localparam logic [7:0]  CHR_LT      = 8'h3C;
    localparam logic [7:0]  CHR_HASH    = 8'h23;
    localparam logic [7:0]  CHR_BANG    = 8'h21;
    localparam logic [7:0]  NUL_BYTE    = 8'h00;

    // Replacements for CJK punctuation 3000..301F
    localparam logic [7:0] CJK_PUNCT [32] = '{
        8'h20, 8'h2C, 8'h2E, 8'h22, 8'h23, 8'h23, 8'h23, 8'h30,
        8'h3C, 8'h3E, 8'hAB, 8'hBB, 8'h5B, 8'h5D, 8'h5B, 8'h5D,
        8'h5B, 8'h5D, 8'h23, 8'h23, 8'h5B, 8'h5D, 8'h5B, 8'h5D,
        8'h5B, 8'h5D, 8'h5B, 8'h5D, 8'h7E, 8'h22, 8'h22, 8'h22
    };

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } byte_item_t;

    typedef struct packed {
        logic       cv;
        logic [7:0] ch;
        logic       done;
        logic       bad;
    } char_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    logic [u2a_pkg::BYTE_W-1:0] in_byte = '0;
    logic end_of_string = 1'b0;
    logic empty;
    logic pop = 1'b0;
    logic char_valid;
    logic [u2a_pkg::BYTE_W-1:0] ascii_char;
    logic string_done;
    logic malformed;

    byte_item_t   pending_bytes[$];
    char_result_t expected_chars[$];
    logic [7:0]   str_buf[$];

    // Decoder state of the prediction
    logic [1:0]  seq_left = '0;
    logic [20:0] cp_accum = '0;
    logic        halted = 1'b0;

    int unsigned errors = 0;
    int unsigned results_seen = 0;
    int unsigned cycle_count = 0;
    int unsigned random_bytes = 0;

    // Sender burst state
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    byte_item_t  next_item;

    // Receiver stall state
    int unsigned seg_left = 0;
    int unsigned stall_pct = 0;
    int unsigned hold_left = 0;
    bit          long_hold_done = 1'b0;
    char_result_t want;

    utf8_to_ascii_lowering DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .in_byte       (in_byte),
        .end_of_string (end_of_string),
        .empty         (empty),
        .pop           (pop),
        .char_valid    (char_valid),
        .ascii_char    (ascii_char),
        .string_done   (string_done),
        .malformed     (malformed)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Lower one completed code point to an 8-bit character
    function automatic logic [7:0] fold_code_point(input logic [20:0] cp);
        logic [20:0] off;
        off = cp - CP_FW_LO;
        if (cp <= 21'h7F)
            return cp[7:0];
        if (cp >= CP_FW_LO && cp <= CP_FW_HI)
            return CHR_BANG + off[7:0];
        if (cp >= CP_SP_LO && cp <= CP_SP_HI)
            return CHR_SPACE;
        if (cp == CP_NARROW)
            return CHR_NBSP;
        if (cp == CP_MATH_SP || cp == CP_FILLER)
            return CHR_SPACE;
        if (cp >= CP_PUNCT_LO && cp <= CP_PUNCT_HI)
            return CJK_PUNCT[cp[4:0]];
        if (cp == CP_REPEAT)
            return CHR_LT;
        return CHR_HASH;
    endfunction

    // Advance the decoder by one transferred byte and queue its result
    task automatic predict_char(input logic [7:0] b, input logic last);
        char_result_t r;
        r = '0;
        if (!halted)
        begin
            if (seq_left != 2'd0)
            begin
                cp_accum = {cp_accum[14:0], b[5:0]};
                seq_left = seq_left - 2'd1;
                if (seq_left == 2'd0)
                begin
                    r.cv = 1'b1;
                    r.ch = fold_code_point(cp_accum);
                end
            end
            else if (b == NUL_BYTE)
                halted = 1'b1;
            else if (b <= 8'h7F)
            begin
                r.cv = 1'b1;
                r.ch = b;
            end
            else if (b <= 8'hDF)
            begin
                cp_accum = {16'd0, b[4:0]};
                seq_left = 2'd1;
            end
            else if (b <= 8'hEF)
            begin
                cp_accum = {17'd0, b[3:0]};
                seq_left = 2'd2;
            end
            else
            begin
                cp_accum = {18'd0, b[2:0]};
                seq_left = 2'd3;
            end
        end
        if (last)
        begin
            r.done = 1'b1;
            r.bad = (seq_left != 2'd0);
            seq_left = '0;
            cp_accum = '0;
            halted = 1'b0;
        end
        expected_chars.insert(expected_chars.size(), r);
    endtask

    task automatic report_mismatch(input string what);
        if (errors < MAX_PRINTS)
            $display("mismatch at result %0d: %s", results_seen, what);
        errors++;
    endtask

    // Append one byte to the string being built
    task automatic append_byte(input logic [7:0] b);
        str_buf.insert(str_buf.size(), b);
    endtask

    // Continuation byte with random top bits, which the block ignores
    function automatic logic [7:0] cont_byte(input logic [5:0] six);
        logic [1:0] top;
        top = 2'($urandom_range(3));
        return {top, six};
    endfunction

    // Append one code point in n bytes; longer than needed gives overlong forms
    task automatic add_code_point(input logic [20:0] cp, input int nbytes);
        logic [2:0] lead2_top;
        lead2_top = 3'b100 + 3'($urandom_range(2));
        case (nbytes)
            1: append_byte(cp[7:0]);
            2:
            begin
                append_byte({lead2_top, cp[10:6]});
                append_byte(cont_byte(cp[5:0]));
            end
            3:
            begin
                append_byte({4'hE, cp[15:12]});
                append_byte(cont_byte(cp[11:6]));
                append_byte(cont_byte(cp[5:0]));
            end
            default:
            begin
                append_byte({4'hF, 1'($urandom_range(1)), cp[20:18]});
                append_byte(cont_byte(cp[17:12]));
                append_byte(cont_byte(cp[11:6]));
                append_byte(cont_byte(cp[5:0]));
            end
        endcase
    endtask

    function automatic logic [20:0] pick_code_point();
        case ($urandom_range(11))
            0, 1, 2: return 21'($urandom_range(1, 127));
            3:       return 21'($urandom_range(CP_FW_LO - 1, CP_FW_HI + 1));
            4:       return 21'($urandom_range(CP_SP_LO - 1, CP_SP_HI + 1));
            5:
            begin
                case ($urandom_range(5))
                    0:       return CP_NARROW;
                    1:       return CP_MATH_SP;
                    2:       return CP_FILLER;
                    3:       return CP_REPEAT;
                    4:       return CP_REPEAT + 21'd1;
                    default: return CP_NARROW - 21'd1;
                endcase
            end
            6, 7:    return 21'($urandom_range(CP_PUNCT_LO - 1, CP_PUNCT_HI + 1));
            8:       return 21'($urandom_range(12'h080, 12'h7FF));
            9:       return 21'($urandom_range(16'h0800, 16'hFFFF));
            default: return 21'($urandom_range(21'h010000, 21'h1FFFFF));
        endcase
    endfunction

    // Append a random code point, now and then in an overlong form
    task automatic add_random_char();
        logic [20:0] cp;
        int n;
        cp = pick_code_point();
        if (cp < 21'h80)
            n = 1;
        else if (cp < 21'h800)
            n = 2;
        else if (cp < 21'h10000)
            n = 3;
        else
            n = 4;
        if (n < 4 && $urandom_range(7) == 0)
            n = n + $urandom_range(1, 4 - n);
        add_code_point(cp, n);
    endtask

    // Append a lead byte with too few continuations
    task automatic add_partial();
        int n;
        n = $urandom_range(2, 4);
        case (n)
            2:       append_byte({3'b100 + 3'($urandom_range(2)),
                                  5'($urandom_range(31))});
            3:       append_byte({4'hE, 4'($urandom_range(15))});
            default: append_byte({4'hF, 4'($urandom_range(15))});
        endcase
        repeat ($urandom_range(0, n - 2))
            append_byte(cont_byte(6'($urandom_range(63))));
    endtask

    // Move the built string to the sender, flagging its final byte
    task automatic flush_string();
        for (int i = 0; i < str_buf.size(); i++)
            pending_bytes.insert(pending_bytes.size(),
                                 byte_item_t'{data: str_buf[i],
                                              last: (i == str_buf.size() - 1)});
        random_bytes += str_buf.size();
        str_buf.delete();
    endtask

    task automatic add_random_string();
        int kind;
        kind = $urandom_range(99);
        if (kind < 90)
        begin
            repeat ($urandom_range(1, 10))
                add_random_char();
            if (kind >= 70 && kind < 80)
            begin
                // stop the string, then keep feeding bytes it must ignore
                append_byte(NUL_BYTE);
                repeat ($urandom_range(0, 4))
                    add_random_char();
                if ($urandom_range(1) == 1)
                    add_partial();
            end
            else if (kind >= 80)
                add_partial();
        end
        else
        begin
            repeat ($urandom_range(1, 8))
                append_byte(8'($urandom_range(255)));
        end
        flush_string();
    endtask

    task automatic wait_drained();
        while (pending_bytes.size() != 0 || push || expected_chars.size() != 0)
            @(negedge clk);
    endtask

    // Sender: offer queued bytes in bursts separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            in_byte <= '0;
            end_of_string <= 1'b0;
        end
        else
        begin
            if (push && !full)
                predict_char(in_byte, end_of_string);
            if (!push || !full)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    push <= 1'b0;
                end
                else if (pending_bytes.size() != 0)
                begin
                    next_item = pending_bytes.pop_front();
                    push <= 1'b1;
                    in_byte <= next_item.data;
                    end_of_string <= next_item.last;
                    if (burst_left == 0)
                        burst_left = $urandom_range(1, 40);
                    burst_left--;
                    if (burst_left == 0)
                        gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // Receiver: check each transfer, stall on segments of varying density
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (expected_chars.size() == 0)
                    report_mismatch("result with nothing expected");
                else
                begin
                    want = expected_chars.pop_front();
                    if (char_valid !== want.cv)
                        report_mismatch($sformatf("char_valid %b, expected %b",
                                                  char_valid, want.cv));
                    if (ascii_char !== want.ch)
                        report_mismatch($sformatf("ascii_char %h, expected %h",
                                                  ascii_char, want.ch));
                    if (string_done !== want.done)
                        report_mismatch($sformatf("string_done %b, expected %b",
                                                  string_done, want.done));
                    if (malformed !== want.bad)
                        report_mismatch($sformatf("malformed %b, expected %b",
                                                  malformed, want.bad));
                end
                results_seen++;
            end
            // hold off once for a long stretch so the block backs up
            if (!long_hold_done && results_seen >= 400)
            begin
                long_hold_done = 1'b1;
                hold_left = 150;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    seg_left = $urandom_range(10, 60);
                    case ($urandom_range(3))
                        0:       stall_pct = 0;
                        1:       stall_pct = 25;
                        2:       stall_pct = 60;
                        default: stall_pct = 90;
                    endcase
                end
                seg_left--;
                pop <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // ASCII extremes
        str_buf = '{8'h01, 8'h7F};
        flush_string();
        // fullwidth first and last
        str_buf = '{8'hEF, 8'hBC, 8'h81, 8'hEF, 8'hBD, 8'h9E};
        flush_string();
        // widest code point, all ones
        str_buf = '{8'hFF, 8'hBF, 8'hBF, 8'hBF};
        flush_string();
        // em space and narrow no-break space
        str_buf = '{8'hE2, 8'h80, 8'h83, 8'hE2, 8'h80, 8'hAF};
        flush_string();
        // NUL lead stops the rest of the string
        str_buf = '{8'h61, NUL_BYTE, 8'h62};
        flush_string();
        // NUL taken as a continuation byte
        str_buf = '{8'hC0, NUL_BYTE};
        flush_string();
        // string ends inside a sequence
        str_buf = '{8'hE3, 8'h80};
        flush_string();

        // hold the sender until every directed result is back
        wait_drained();

        random_bytes = 0;
        while (random_bytes < RANDOM_BYTES)
            add_random_string();

        wait_drained();
        repeat (10) @(negedge clk);
        if (errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

// File: files.f
rtl/core/u2a_pkg.sv
rtl/core/u2a_front.sv
rtl/core/u2a_queue.sv
rtl/core/u2a_back.sv
rtl/core/utf8_to_ascii_lowering.sv
sim/testbench.sv
